// ===== rtl/kepler_pkg.sv =====
package kepler_pkg;

   // default configuration
   localparam int NEWTON_STEPS_DEF    = 6;
   localparam int ANGLE_FRAC_BITS_DEF = 28;

   // field widths and fixed formats
   localparam int M_W          = 32;
   localparam int E_W          = 24;
   localparam int ECC_FRAC     = 24;
   localparam int CORDIC_ITERS = 30;
   localparam int QB           = 31;   // quotient bits, quotient below 2^31
   localparam int XW           = 34;   // CORDIC x and y
   localparam int ZW           = 33;   // CORDIC residual angle
   localparam int RW           = 35;   // reduced angle, numerator, products after shift
   localparam int DW           = 34;   // divisor and partial remainder

   localparam logic signed [RW-1:0] ONE_Q30     = 35'sd1073741824;
   localparam logic signed [RW-1:0] PI_Q30      = 35'sd3373259426;
   localparam logic signed [RW-1:0] HALF_PI_Q30 = 35'sd1686629713;
   localparam logic signed [RW-1:0] TWO_PI_Q30  = 35'sd6746518852;
   localparam logic signed [XW-1:0] GAIN_Q30    = 34'sd652032874;

   localparam logic signed [M_W-1:0] S32_MAX = 32'sh7fffffff;
   localparam logic signed [M_W-1:0] S32_MIN = 32'sh80000000;

   // arctangent of 2^-i in Q.30, rounded
   localparam logic signed [ZW-1:0] ATAN_Q30 [0:CORDIC_ITERS-1] = '{
      33'sd843314857, 33'sd497837829, 33'sd263043837, 33'sd133525159,
      33'sd67021687,  33'sd33543516,  33'sd16775851,  33'sd8388437,
      33'sd4194283,   33'sd2097149,   33'sd1048576,   33'sd524288,
      33'sd262144,    33'sd131072,    33'sd65536,     33'sd32768,
      33'sd16384,     33'sd8192,      33'sd4096,      33'sd2048,
      33'sd1024,      33'sd512,       33'sd256,       33'sd128,
      33'sd64,        33'sd32,        33'sd16,        33'sd8,
      33'sd4,         33'sd2
   };

   // item payload carried down the pipeline
   typedef struct packed {
      logic signed [M_W-1:0] m;
      logic [E_W-1:0]        e;
      logic signed [M_W-1:0] ang;
   } carry_type;

endpackage

// ===== rtl/kepler_equation_newton_solver.sv =====
// Solves Kepler's equation E - e*sin(E) = M with NEWTON_STEPS Newton steps from E = M,
// each step a fully pipelined unit (range reduction, 30-stage CORDIC, eccentricity
// multipliers, 31-stage restoring divider). One item is taken in every clock cycle;
// busy is high only during reset. The result of an item strobes on rsp_strobe once
// the item has passed through the stages of every Newton step, in the order the items
// were started. The receiver cannot stall: each result is on the rsp_ ports for exactly
// one cycle.
module kepler_equation_newton_solver #(
   parameter int NEWTON_STEPS    = kepler_pkg::NEWTON_STEPS_DEF,
   parameter int ANGLE_FRAC_BITS = kepler_pkg::ANGLE_FRAC_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic signed [kepler_pkg::M_W-1:0]   req_mean_anomaly,
   input  logic [kepler_pkg::E_W-1:0]          req_eccentricity,
   output logic                                rsp_strobe,
   output logic signed [kepler_pkg::M_W-1:0]   rsp_eccentric_anomaly
);

   logic                  st_valid [NEWTON_STEPS+1];
   kepler_pkg::carry_type st_carry [NEWTON_STEPS+1];

   // hold off beats only while in reset
   assign busy = reset;

   // start each beat with E = M
   assign st_valid[0]       = start & ~busy;
   assign st_carry[0].m     = req_mean_anomaly;
   assign st_carry[0].e     = req_eccentricity;
   assign st_carry[0].ang   = req_mean_anomaly;

   // chain the Newton step pipelines
   for (genvar n = 0; n < NEWTON_STEPS; n++) begin : g_step
      kepler_step #(
         .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
      ) u_step (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (st_valid[n]),
         .in_carry  (st_carry[n]),
         .out_valid (st_valid[n+1]),
         .out_carry (st_carry[n+1])
      );
   end

   assign rsp_strobe            = st_valid[NEWTON_STEPS];
   assign rsp_eccentric_anomaly = st_carry[NEWTON_STEPS].ang;

endmodule

// ===== rtl/kepler_step.sv =====
module kepler_step #(
   parameter int ANGLE_FRAC_BITS = kepler_pkg::ANGLE_FRAC_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  kepler_pkg::carry_type in_carry,
   output logic                  out_valid,
   output kepler_pkg::carry_type out_carry
);

   localparam int RW     = kepler_pkg::RW;
   localparam int XW     = kepler_pkg::XW;
   localparam int ZW     = kepler_pkg::ZW;
   localparam int DW     = kepler_pkg::DW;
   localparam int QB     = kepler_pkg::QB;
   localparam int M_W    = kepler_pkg::M_W;
   localparam int NIT    = kepler_pkg::CORDIC_ITERS;
   localparam int SHIFT  = 30 - ANGLE_FRAC_BITS;
   localparam int WA     = M_W + SHIFT;
   localparam int RED_N  = SHIFT;
   localparam int PW     = XW + kepler_pkg::E_W + 1;
   localparam int ES_SH  = kepler_pkg::ECC_FRAC + SHIFT;

   // stage numbers
   localparam int S_WRAP = RED_N + 1;
   localparam int S_FOLD = RED_N + 2;
   localparam int S_MUL  = S_FOLD + NIT + 1;
   localparam int S_ND   = S_MUL + 1;
   localparam int S_MAG  = S_ND + 1;
   localparam int S_DIV  = S_MAG + 1;
   localparam int S_UPD  = S_DIV + QB;
   localparam int NST    = S_UPD + 1;

   localparam logic [WA-1:0] TWO_PI_W = WA'(kepler_pkg::TWO_PI_Q30);

   logic [NST-1:0]        v_ff;
   kepler_pkg::carry_type c_ff [NST];
   kepler_pkg::carry_type upd_in;

   logic [WA-1:0]         red_mag_ff [RED_N+1];
   logic                  red_neg_ff [RED_N+1];
   logic [WA-1:0]         red_mag_in [RED_N];
   logic signed [WA-1:0]  ang_w;

   logic signed [RW-1:0]  wrap_ff, wrap_in;
   logic signed [ZW-1:0]  fold_z_in;
   logic                  fold_f_in;

   logic signed [XW-1:0]  cx_ff [NIT+1];
   logic signed [XW-1:0]  cy_ff [NIT+1];
   logic signed [ZW-1:0]  cz_ff [NIT+1];
   logic                  cf_ff [NIT+1];
   logic signed [XW-1:0]  cx_in [NIT];
   logic signed [XW-1:0]  cy_in [NIT];
   logic signed [ZW-1:0]  cz_in [NIT];

   logic signed [RW-1:0]  es_ff, ec_ff, es_in, ec_in;
   logic signed [RW-1:0]  num_ff, num_in;
   logic [DW-1:0]         den_ff, den_in;
   logic [RW-1:0]         mag_ff, mag_in;
   logic                  sat_ff, sat_in, neg_ff;
   logic [DW-1:0]         mden_ff;

   logic [DW-1:0]         drem_ff [QB];
   logic [QB-1:0]         dq_ff   [QB];
   logic [DW-1:0]         dden_ff [QB];
   logic                  dsat_ff [QB];
   logic                  dneg_ff [QB];
   logic [DW-1:0]         drem_in [QB];
   logic [QB-1:0]         dq_in   [QB];

   // advance valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= {v_ff[NST-2:0], in_valid};
      end
   end

   // advance payload, replace the angle at the update stage
   always_ff @(posedge clock) begin
      c_ff[0] <= in_carry;
      for (int k = 1; k < NST; k++) begin
         c_ff[k] <= (k == S_UPD) ? upd_in : c_ff[k-1];
      end
   end

   // widen angle to Q.30, take magnitude
   assign ang_w = {in_carry.ang, {SHIFT{1'b0}}};

   // subtract multiples of two pi, largest first
   always_comb begin
      for (int j = 0; j < RED_N; j++) begin
         if (red_mag_ff[j] >= (TWO_PI_W << (RED_N - 1 - j))) begin
            red_mag_in[j] = red_mag_ff[j] - (TWO_PI_W << (RED_N - 1 - j));
         end else begin
            red_mag_in[j] = red_mag_ff[j];
         end
      end
   end

   always_ff @(posedge clock) begin
      red_mag_ff[0] <= ang_w[WA-1] ? (~ang_w + 1'b1) : ang_w;
      red_neg_ff[0] <= ang_w[WA-1];
      for (int j = 0; j < RED_N; j++) begin
         red_mag_ff[j+1] <= red_mag_in[j];
         red_neg_ff[j+1] <= red_neg_ff[j];
      end
   end

   // restore sign, wrap into [-pi, pi]
   always_comb begin
      logic signed [RW-1:0] r;
      r = RW'(red_mag_ff[RED_N]);
      if (red_neg_ff[RED_N]) begin
         r = -r;
      end
      if (r > kepler_pkg::PI_Q30) begin
         wrap_in = r - kepler_pkg::TWO_PI_Q30;
      end else if (r < -kepler_pkg::PI_Q30) begin
         wrap_in = r + kepler_pkg::TWO_PI_Q30;
      end else begin
         wrap_in = r;
      end
   end

   always_ff @(posedge clock) begin
      wrap_ff <= wrap_in;
   end

   // fold into [-pi/2, pi/2], remember cosine sign flip
   always_comb begin
      if (wrap_ff > kepler_pkg::HALF_PI_Q30) begin
         fold_z_in = ZW'(kepler_pkg::PI_Q30 - wrap_ff);
         fold_f_in = 1'b1;
      end else if (wrap_ff < -kepler_pkg::HALF_PI_Q30) begin
         fold_z_in = ZW'(-kepler_pkg::PI_Q30 - wrap_ff);
         fold_f_in = 1'b1;
      end else begin
         fold_z_in = ZW'(wrap_ff);
         fold_f_in = 1'b0;
      end
   end

   // rotate one CORDIC step per stage
   always_comb begin
      for (int i = 0; i < NIT; i++) begin
         if (cz_ff[i] >= 0) begin
            cx_in[i] = cx_ff[i] - (cy_ff[i] >>> i);
            cy_in[i] = cy_ff[i] + (cx_ff[i] >>> i);
            cz_in[i] = cz_ff[i] - kepler_pkg::ATAN_Q30[i];
         end else begin
            cx_in[i] = cx_ff[i] + (cy_ff[i] >>> i);
            cy_in[i] = cy_ff[i] - (cx_ff[i] >>> i);
            cz_in[i] = cz_ff[i] + kepler_pkg::ATAN_Q30[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      cx_ff[0] <= kepler_pkg::GAIN_Q30;
      cy_ff[0] <= '0;
      cz_ff[0] <= fold_z_in;
      cf_ff[0] <= fold_f_in;
      for (int i = 0; i < NIT; i++) begin
         cx_ff[i+1] <= cx_in[i];
         cy_ff[i+1] <= cy_in[i];
         cz_ff[i+1] <= cz_in[i];
         cf_ff[i+1] <= cf_ff[i];
      end
   end

   // scale sine and cosine by eccentricity, floor
   always_comb begin
      logic signed [XW-1:0] cos_v;
      logic signed [PW-1:0] pes, pec;
      cos_v = cf_ff[NIT] ? -cx_ff[NIT] : cx_ff[NIT];
      pes   = $signed({1'b0, c_ff[S_MUL-1].e}) * cy_ff[NIT];
      pec   = $signed({1'b0, c_ff[S_MUL-1].e}) * cos_v;
      es_in = RW'(pes >>> ES_SH);
      ec_in = RW'(pec >>> kepler_pkg::ECC_FRAC);
   end

   always_ff @(posedge clock) begin
      es_ff <= es_in;
      ec_ff <= ec_in;
   end

   // form numerator and denominator
   always_comb begin
      logic signed [RW-1:0] d;
      d = kepler_pkg::ONE_Q30 - ec_ff;
      den_in = (d < 1) ? DW'(1) : DW'(d);
      num_in = RW'(c_ff[S_ND-1].ang) - es_ff - RW'(c_ff[S_ND-1].m);
   end

   always_ff @(posedge clock) begin
      den_ff <= den_in;
      num_ff <= num_in;
   end

   // take magnitude, flag quotient overflow
   always_comb begin
      mag_in = num_ff[RW-1] ? RW'(-num_ff) : RW'(num_ff);
      sat_in = mag_in >= {den_ff, 1'b0};
   end

   always_ff @(posedge clock) begin
      mag_ff  <= mag_in;
      sat_ff  <= sat_in;
      neg_ff  <= num_ff[RW-1];
      mden_ff <= den_ff;
   end

   // restoring divide, one quotient bit per stage
   always_comb begin
      logic ge;
      logic [DW-1:0] rr;
      ge = mag_ff >= RW'(mden_ff);
      if (sat_ff) begin
         drem_in[0] = '0;
      end else if (ge) begin
         drem_in[0] = DW'(mag_ff - RW'(mden_ff));
      end else begin
         drem_in[0] = DW'(mag_ff);
      end
      dq_in[0] = {ge, {(QB-1){1'b0}}};
      for (int t = 1; t < QB; t++) begin
         rr = drem_ff[t-1] << 1;
         if (rr >= dden_ff[t-1]) begin
            drem_in[t] = rr - dden_ff[t-1];
            dq_in[t]   = dq_ff[t-1] | (QB'(1) << (QB - 1 - t));
         end else begin
            drem_in[t] = rr;
            dq_in[t]   = dq_ff[t-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      drem_ff[0] <= drem_in[0];
      dq_ff[0]   <= dq_in[0];
      dden_ff[0] <= mden_ff;
      dsat_ff[0] <= sat_ff;
      dneg_ff[0] <= neg_ff;
      for (int t = 1; t < QB; t++) begin
         drem_ff[t] <= drem_in[t];
         dq_ff[t]   <= dq_in[t];
         dden_ff[t] <= dden_ff[t-1];
         dsat_ff[t] <= dsat_ff[t-1];
         dneg_ff[t] <= dneg_ff[t-1];
      end
   end

   // apply sign and saturation, step the angle
   always_comb begin
      logic [M_W-1:0]        qmag;
      logic signed [M_W-1:0] qc;
      logic signed [M_W+1:0] ne;
      qmag = dsat_ff[QB-1] ? {1'b1, {(M_W-1){1'b0}}} : {1'b0, dq_ff[QB-1]};
      if (dneg_ff[QB-1]) begin
         qc = $signed(~qmag + 1'b1);
      end else if (dsat_ff[QB-1]) begin
         qc = kepler_pkg::S32_MAX;
      end else begin
         qc = $signed(qmag);
      end
      ne = (M_W+2)'(c_ff[S_UPD-1].ang) - (M_W+2)'(qc);
      upd_in = c_ff[S_UPD-1];
      if (ne > (M_W+2)'(kepler_pkg::S32_MAX)) begin
         upd_in.ang = kepler_pkg::S32_MAX;
      end else if (ne < (M_W+2)'(kepler_pkg::S32_MIN)) begin
         upd_in.ang = kepler_pkg::S32_MIN;
      end else begin
         upd_in.ang = M_W'(ne);
      end
   end

   assign out_valid = v_ff[NST-1];
   assign out_carry = c_ff[NST-1];

   a_wrap_range: assert property (@(posedge clock) disable iff (reset)
      v_ff[S_WRAP] |-> (wrap_ff <= kepler_pkg::PI_Q30 && wrap_ff >= -kepler_pkg::PI_Q30))
      else $error("reduced angle outside [-pi, pi]");

   a_den_positive: assert property (@(posedge clock) disable iff (reset)
      v_ff[S_ND] |-> den_ff != '0)
      else $error("divisor is zero");

   a_rem_below_den: assert property (@(posedge clock) disable iff (reset)
      v_ff[S_UPD-1] |-> drem_ff[QB-1] < dden_ff[QB-1])
      else $error("final remainder not below divisor");

endmodule

// ===== tb/sv/kepler_checker.sv =====
module kepler_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic                              busy,
   input  logic signed [kepler_pkg::M_W-1:0] req_mean_anomaly,
   input  logic [kepler_pkg::E_W-1:0]        req_eccentricity,
   input  logic                              rsp_strobe,
   input  logic signed [kepler_pkg::M_W-1:0] rsp_eccentric_anomaly,
   output int                                fail_count,
   output int                                pending_count,
   output int                                solved_count
);

   localparam int FRAC     = kepler_pkg::ANGLE_FRAC_BITS_DEF;
   localparam int M_W      = kepler_pkg::M_W;
   localparam int E_W      = kepler_pkg::E_W;
   localparam int ECC_FRAC = kepler_pkg::ECC_FRAC;
   localparam int STEPS    = kepler_pkg::NEWTON_STEPS_DEF;

   logic signed [M_W-1:0] anomaly_queue[$];

   // CORDIC sine and cosine of an angle in Q.30
   task automatic sin_cos(input longint a, output longint s, output longint c);
      longint r, x, y, z, nx;
      bit flip;
      const longint atan_tab[30] = '{
         843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
         16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144,
         131072, 65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256,
         128, 64, 32, 16, 8, 4, 2};
      r = a % 64'sd6746518852;
      flip = 0;
      if (r > 64'sd3373259426) r -= 64'sd6746518852;
      else if (r < -64'sd3373259426) r += 64'sd6746518852;
      if (r > 64'sd1686629713) begin
         r = 64'sd3373259426 - r;
         flip = 1;
      end else if (r < -64'sd1686629713) begin
         r = -64'sd3373259426 - r;
         flip = 1;
      end
      x = 652032874;
      y = 0;
      z = r;
      for (int i = 0; i < 30; i++) begin
         if (z >= 0) begin
            nx = x - (y >>> i);
            y = y + (x >>> i);
            z -= atan_tab[i];
         end else begin
            nx = x + (y >>> i);
            y = y - (x >>> i);
            z += atan_tab[i];
         end
         x = nx;
      end
      s = y;
      c = flip ? -x : x;
   endtask

   function automatic longint sat32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   // run the Newton iteration for one beat
   task automatic solve_anomaly(input logic signed [M_W-1:0] mean,
                                input logic [E_W-1:0] ecc,
                                output logic signed [M_W-1:0] ecc_anom);
      longint m, e, ea, s, c, es, ec, den, num, mag, q;
      m = longint'(mean);
      e = longint'(ecc);
      ea = m;
      for (int k = 0; k < STEPS; k++) begin
         sin_cos(ea * (64'sd1 << (30 - FRAC)), s, c);
         es = (e * s) >>> (ECC_FRAC + 30 - FRAC);
         ec = (e * c) >>> ECC_FRAC;
         den = 64'sd1073741824 - ec;
         if (den < 1) den = 1;
         num = ea - es - m;
         mag = num < 0 ? -num : num;
         if (mag >= 2 * den) q = 64'sd2147483648;
         else q = (mag * 64'sd1073741824) / den;
         if (num < 0) q = -q;
         q = sat32(q);
         ea = sat32(ea - q);
      end
      ecc_anom = ea[31:0];
   endtask

   // predict on each accepted start beat, compare each result beat
   always @(posedge clock) begin
      logic signed [M_W-1:0] predicted;
      if (reset) begin
         anomaly_queue.delete();
         fail_count <= 0;
         solved_count <= 0;
      end else begin
         if (start && !busy) begin
            solve_anomaly(req_mean_anomaly, req_eccentricity, predicted);
            anomaly_queue.push_back(predicted);
         end
         if (rsp_strobe) begin
            if (anomaly_queue.size() == 0) begin
               $error("unexpected result beat: eccentric_anomaly %0d", rsp_eccentric_anomaly);
               fail_count <= fail_count + 1;
            end else begin
               predicted = anomaly_queue.pop_front();
               solved_count <= solved_count + 1;
               if (predicted !== rsp_eccentric_anomaly) begin
                  $error("eccentric_anomaly expected %0d actual %0d",
                         predicted, rsp_eccentric_anomaly);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
      pending_count <= anomaly_queue.size();
   end
endmodule

// ===== tb/sv/tb.sv =====
module tb;

   localparam int M_W = kepler_pkg::M_W;
   localparam int E_W = kepler_pkg::E_W;

   logic                  clock = 0;
   logic                  reset = 1;
   logic                  start = 0;
   logic                  busy;
   logic signed [M_W-1:0] req_mean_anomaly = '0;
   logic [E_W-1:0]        req_eccentricity = '0;
   logic                  rsp_strobe;
   logic signed [M_W-1:0] rsp_eccentric_anomaly;
   int                    fail_count, pending_count, solved_count;
   int                    idle_pct;

   always begin
      #6 clock = 1;
      #6 clock = 0;
   end

   kepler_equation_newton_solver DUT (.*);

   kepler_checker chk (.*);

   // hand one beat to the block, idling first at the given rate
   task automatic send_beat(input logic signed [M_W-1:0] m, input logic [E_W-1:0] e);
      while ($urandom_range(99) < idle_pct) begin
         start <= 0;
         @(negedge clock);
      end
      start <= 1;
      req_mean_anomaly <= m;
      req_eccentricity <= e;
      @(posedge clock);
      while (busy) @(posedge clock);
      @(negedge clock);
   endtask

   function automatic logic [E_W-1:0] rand_ecc();
      case ($urandom_range(3))
         0: return E_W'($urandom_range(16777215));
         1: return 24'hFFFFFF - E_W'($urandom_range(255));
         2: return E_W'($urandom_range(255));
         default: return E_W'($urandom_range(16777215, 12000000));
      endcase
   endfunction

   initial begin
      logic signed [M_W-1:0] dm[] = '{0, 1, -1, 32'sh7fffffff, 32'sh80000000,
                                     32'sd843314857, -32'sd843314857, 32'sd1686629713,
                                     32'sd536870912, -32'sd536870912};
      logic [E_W-1:0] de[] = '{24'd0, 24'd1, 24'hFFFFFF, 24'h800000, 24'hFFFFFE};
      int phase_pct[4] = '{0, 84, 0, 36};
      idle_pct = 0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      @(negedge clock);
      // directed: angle and eccentricity extremes, wrap at plus and minus pi
      for (int i = 0; i < 5; i++) send_beat(dm[i], de[i]);
      for (int i = 0; i < 10; i++) send_beat(dm[i], de[(i + 2) % 5]);
      send_beat(32'sd843314857, 24'hFFFFFF);
      send_beat(-32'sd1686629713, 24'hFFFFFF);
      // random phases with varied idling
      for (int p = 0; p < 4; p++) begin
         idle_pct = phase_pct[p];
         for (int n = 0; n < 300; n++) begin
            if ($urandom_range(1)) send_beat($urandom, rand_ecc());
            else send_beat($signed($urandom_range(2000000000)) - 1000000000, rand_ecc());
         end
      end
      start <= 0;
      while (pending_count != 0) @(negedge clock);
      repeat (450) @(negedge clock);
      $display("covered %0d solved items over four idling phases and directed extremes",
               solved_count);
      if (fail_count == 0 && pending_count == 0)
         $display("kepler_equation_newton_solver: match");
      else
         $display("kepler_equation_newton_solver: mismatch");
      $finish;
   end

   initial begin
      #2000000;
      $display("kepler_equation_newton_solver: mismatch");
      $finish;
   end
endmodule
